// File: hw/rtl/fdf_enc_pkg.sv
package fdf_enc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV_MUL,
    ST_DIV_FIN,
    ST_OUT
  } state_t;

  // float32 patterns of the loop bounds, magnitude only
  localparam logic [30:0] MANT_MAX_BITS = 31'h4AFF_FFFE; // 8388607.0
  localparam logic [30:0] ONE_BITS      = 31'h3F80_0000; // 1.0
  localparam logic [7:0]  EXP_ALL_ONES  = 8'hFF;
  localparam logic [7:0]  EXP_TRUNC_REF = 8'd150;        // bias + 23
  localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD; // ceil(2^35 / 10)
  localparam int unsigned RECIP_SHIFT   = 35;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOT_ENC  = 1'b1;

endpackage

// File: hw/rtl/float_to_decimal_float_encoder.sv
// Channel | Direction | tdata / tuser
// s       | in        | tdata[31:0] value_bits
// m       | out       | tdata[23:0] mantissa, tdata[31:24] exponent; tuser[0] status
//
// One request at a time; s_tready is high only when idle.
// Each divide-by-ten step passes the compare, reciprocal multiply and round states,
// each multiply-by-ten step the compare state alone, and a last pass truncates:
// the time to a finite non-zero result after acceptance is set by the number of
// decimal scaling steps through the shared unit.
// Zero, infinity and NaN give a result the cycle after acceptance.
// A result waits in the output register until m_tready, then the block returns
// to idle; rst is synchronous.
module float_to_decimal_float_encoder
  import fdf_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] mantissa, [31:24] exponent
  output logic [0:0]  m_tuser    // [0] status
);

  state_t state, state_next;

  logic [30:0] mag, mag_next;
  logic        neg, neg_next;
  logic [7:0]  exp10, exp10_next;
  logic [60:0] prod, prod_next;
  logic [28:0] divd, divd_next;
  logic [23:0] mant_out, mant_out_next;
  logic [7:0]  exp_out, exp_out_next;
  logic        stat_out, stat_out_next;

  // unpacked magnitude
  logic [7:0]  ef;
  logic [23:0] sig;
  logic [7:0]  eff_e;

  // multiply by ten
  logic [27:0] p10;
  logic [2:0]  k;
  logic [23:0] mshift;
  logic        mg, mst;
  logic [30:0] mul_res;

  // divide by ten finish
  logic [25:0] q;
  logic [28:0] rem;
  logic [23:0] dm;
  logic        dg, dst;
  logic [7:0]  de;
  logic [30:0] div_res;

  // truncation
  logic [4:0]  tsh;
  logic [23:0] tint;

  always_comb begin
    ef    = mag[30:23];
    sig   = {(ef != 8'd0), mag[22:0]};
    eff_e = (ef == 8'd0) ? 8'd1 : ef;

    p10 = {4'd0, sig} * 28'd10;
    k   = 3'd0;
    for (int i = 1; i <= 4; i++) begin
      if (p10[23 + i]) k = 3'(i);
    end
    mshift = 24'(p10 >> k);
    mg  = 1'b0;
    mst = 1'b0;
    for (int i = 1; i <= 4; i++) begin
      if (3'(i) == k) begin
        mg  = p10[i - 1];
        mst = (i > 1) ? |(p10 & ((28'd1 << (i - 1)) - 28'd1)) : 1'b0;
      end
    end
    if (!p10[23] && (k == 3'd0)) begin
      mul_res = {8'd0, p10[22:0]}; // still subnormal, exact
    end else begin
      mul_res = {eff_e + 8'(k), mshift[22:0]} + 31'(mg & (mst | mshift[0]));
    end

    q   = prod[RECIP_SHIFT +: 26];
    rem = divd - 29'({q, 3'd0} + {2'd0, q, 1'b0});
    if (q[25]) begin
      dm  = q[25:2];
      dg  = q[1];
      dst = q[0] | (rem != 29'd0);
      de  = ef - 8'd3;
    end else begin
      dm  = q[24:1];
      dg  = q[0];
      dst = (rem != 29'd0);
      de  = ef - 8'd4;
    end
    div_res = {de, dm[22:0]} + 31'(dg & (dst | dm[0]));

    tsh  = 5'(EXP_TRUNC_REF - ef);
    tint = sig >> tsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    neg      <= neg_next;
    exp10    <= exp10_next;
    prod     <= prod_next;
    divd     <= divd_next;
    mant_out <= mant_out_next;
    exp_out  <= exp_out_next;
    stat_out <= stat_out_next;
  end

  always_comb begin
    state_next    = state;
    mag_next      = mag;
    neg_next      = neg;
    exp10_next    = exp10;
    prod_next     = prod;
    divd_next     = divd;
    mant_out_next = mant_out;
    exp_out_next  = exp_out;
    stat_out_next = stat_out;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mag_next      = s_tdata[30:0];
          neg_next      = s_tdata[31];
          exp10_next    = 8'd0;
          mant_out_next = 24'd0;
          exp_out_next  = 8'd0;
          stat_out_next = STATUS_OK;
          if (s_tdata[30:23] == EXP_ALL_ONES) begin
            stat_out_next = STATUS_NOT_ENC;
            state_next    = ST_OUT;
          end else if (s_tdata[30:0] == 31'd0) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (mag > MANT_MAX_BITS) begin
          divd_next  = {sig, 5'd0};
          state_next = ST_DIV_MUL;
        end else if (mag < ONE_BITS) begin
          mag_next   = mul_res;
          exp10_next = exp10 - 8'd1;
        end else begin
          mant_out_next = neg ? 24'(-tint) : tint;
          exp_out_next  = exp10;
          state_next    = ST_OUT;
        end
      end
      ST_DIV_MUL: begin
        prod_next  = 61'({32'd0, divd} * {29'd0, RECIP_TEN});
        state_next = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        mag_next   = div_res;
        exp10_next = exp10 + 8'd1;
        state_next = ST_SCALE;
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready   = (state == ST_IDLE);
  assign m_tvalid   = (state == ST_OUT);
  assign m_tdata    = {exp_out, mant_out};
  assign m_tuser[0] = stat_out;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == STATUS_NOT_ENC) |-> (m_tdata == 32'd0))
    else $error("not-encodable result with non-zero fields");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after a request");

  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_MUL) |=> (state == ST_DIV_FIN))
    else $error("divide step not completed");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import fdf_enc_pkg::*;

  typedef struct packed {
    logic [23:0] mant;
    logic [7:0]  exp10;
    logic        status;
  } enc_t;

  typedef struct packed {
    logic [31:0] bits;
    logic        drain_first; // hold off until every result is back
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value_bits
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [23:0] mantissa, [31:24] exponent
  logic [0:0]  m_tuser;        // [0] status

  sample_t samples_q[$];
  enc_t    encoded_q[$];
  int      errors = 0;
  int      results_seen = 0;
  int      cycles = 0;
  int      gap_left = 0;
  int      burst_left = 4;
  int      hold_left = 0;
  bit      long_hold_done = 1'b0;
  int      stall_mode = 0;

  float_to_decimal_float_encoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // split a float32 magnitude into integer significand and power of two
  function automatic void split_mag(input logic [30:0] mag, output logic [63:0] sig,
                                    output int e2);
    if (mag[30:23] == 8'd0) begin
      sig = {41'd0, mag[22:0]};
      e2 = -149;
    end else begin
      sig = {40'd0, 1'b1, mag[22:0]};
      e2 = int'(mag[30:23]) - 150;
    end
  endfunction

  // round sig * 2^e2 to float32, nearest-even; sticky carries lost bits
  function automatic logic [30:0] round_mag(input logic [63:0] sig, input int e2,
                                            input logic sticky);
    logic guard;
    logic [7:0] be;
    guard = 1'b0;
    while (sig >= 64'h100_0000) begin
      sticky = sticky | guard;
      guard = sig[0];
      sig = sig >> 1;
      e2++;
    end
    if (guard && (sticky || sig[0])) sig++;
    if (sig == 64'h100_0000) begin
      sig = sig >> 1;
      e2++;
    end
    if (sig < 64'h80_0000) return sig[30:0];
    be = 8'(e2 + 150);
    return {be, sig[22:0]};
  endfunction

  function automatic enc_t encode_sample(input logic [31:0] bits);
    enc_t r;
    logic [30:0] mag;
    logic [63:0] sig;
    logic [63:0] num;
    logic [23:0] ipart;
    int e2;
    int k;
    r = '0;
    k = 0;
    mag = bits[30:0];
    if (bits[30:23] == EXP_ALL_ONES) begin
      r.status = STATUS_NOT_ENC;
      return r;
    end
    if (mag == '0) return r;
    while (mag > MANT_MAX_BITS) begin
      split_mag(mag, sig, e2);
      num = sig << 40;
      mag = round_mag(num / 10, e2 - 40, (num % 10) != 0);
      k++;
    end
    while (mag < ONE_BITS) begin
      split_mag(mag, sig, e2);
      mag = round_mag(sig * 10, e2, 1'b0);
      k--;
    end
    split_mag(mag, sig, e2);
    if (e2 >= 0) ipart = 24'(sig << e2);
    else ipart = 24'(sig >> (-e2));
    r.mant = bits[31] ? -ipart : ipart;
    r.exp10 = 8'(k);
    r.status = STATUS_OK;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    sample_t nxt;
    logic    nv;
    bit      fire;
    nv = s_tvalid;
    fire = s_tvalid && s_tready;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (fire) encoded_q.push_back(encode_sample(s_tdata));
      if (!s_tvalid || fire) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_q.size() != 0 &&
                     !(samples_q[0].drain_first && encoded_q.size() != 0)) begin
          nxt = samples_q.pop_front();
          s_tdata <= nxt.bits;
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
    end
    s_tvalid <= nv;
  end

  // monitor
  always @(posedge clk) begin
    enc_t want;
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (encoded_q.size() == 0) begin
          $display("%0t: unexpected result mant=%h exp=%h status=%b", $time,
                   m_tdata[23:0], m_tdata[31:24], m_tuser[0]);
          errors++;
        end else begin
          want = encoded_q.pop_front();
          if (m_tdata[23:0] !== want.mant) begin
            $display("%0t: mantissa expected %h got %h", $time, want.mant, m_tdata[23:0]);
            errors++;
          end
          if (m_tdata[31:24] !== want.exp10) begin
            $display("%0t: exponent expected %h got %h", $time, want.exp10, m_tdata[31:24]);
            errors++;
          end
          if (m_tuser[0] !== want.status) begin
            $display("%0t: status expected %b got %b", $time, want.status, m_tuser[0]);
            errors++;
          end
        end
      end
      if (!long_hold_done && results_seen == 150) begin
        long_hold_done = 1'b1;
        hold_left = 600;
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) hold_left--;
      else case (stall_mode)
        0: nr = 1'b1;
        1: nr = $urandom_range(0, 1);
        default: nr = ($urandom_range(0, 3) == 0);
      endcase
    end
    m_tready <= nr;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[float_to_decimal_float_encoder] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] random_float();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 4))
      0: ; // anything
      1: b[30:23] = 8'($urandom_range(100, 160));     // typical range
      2: b[30:23] = 8'($urandom_range(0, 5));         // tiny and subnormal
      3: b[30:23] = 8'($urandom_range(240, 254));     // huge
      default: b[30:23] = 8'($urandom_range(120, 135));
    endcase
    return b;
  endfunction

  initial begin
    logic [31:0] directed[$];
    sample_t s;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h807F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'h3F7F_FFFF,
                 32'h4AFF_FFFE, 32'h4B00_0000, 32'h4AFF_FFFF, 32'h7F7F_FFFF,
                 32'hFF7F_FFFF, 32'h3DCC_CCCD, 32'hBFC0_0000, 32'h42F6_E979,
                 32'hC1B4_0000, 32'h8000_0001};
    foreach (directed[i]) begin
      s.bits = directed[i];
      s.drain_first = 1'b0;
      samples_q.push_back(s);
    end
    repeat (400) begin
      s.bits = random_float();
      // the first random request always waits for the directed ones to drain
      s.drain_first = (samples_q.size() == directed.size()) ||
                      ($urandom_range(0, 60) == 0);
      samples_q.push_back(s);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (samples_q.size() == 0 && !s_tvalid && encoded_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && encoded_q.size() == 0) begin
      $display("[float_to_decimal_float_encoder] OK");
    end else begin
      $display("[float_to_decimal_float_encoder] ERROR");
    end
    $finish;
  end

endmodule

// File: float_to_decimal_float_encoder.f
hw/rtl/fdf_enc_pkg.sv
hw/rtl/float_to_decimal_float_encoder.sv
tb/sv/tb_top.sv
